[rtl/playfair_cipher_encrypt_macros.svh]
// ============================================================================
// Playfair encryptor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef PLAYFAIR_CIPHER_ENCRYPT_MACROS_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_MACROS_SVH

// Same-cycle implication.
`define PCE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("playfair assertion failed");

// Next-cycle implication.
`define PCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("playfair assertion failed");

`endif

[rtl/pce_pkg.sv]
// ============================================================================
// Playfair encryptor package
// Widths, letter and command codes, and square geometry helpers.
// ============================================================================
`default_nettype none

package pce_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
    localparam int CELL_W      = $clog2(CELL_COUNT);
    localparam int ROW_W       = $clog2(SQUARE_SIDE);
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int FUNC_W      = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - 2 * LETTER_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

    localparam logic [FUNC_W-1:0] FUNC_KEY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MSG  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_END  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [LETTER_W-1:0] code;
    } q_item_t;

    function automatic logic [ROW_W-1:0] cell_row(input logic [CELL_W-1:0] c);
        logic [ROW_W-1:0] row;
        row = '0;
        for (int r = 1; r < SQUARE_SIDE; r++)
        begin
            if (c >= CELL_W'(r * SQUARE_SIDE))
                row = ROW_W'(r);
        end
        return row;
    endfunction

    function automatic logic [CELL_W-1:0] cell_at(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] col);
        return CELL_W'(int'(row) * SQUARE_SIDE + int'(col));
    endfunction

    function automatic logic [ROW_W-1:0] cell_col(input logic [CELL_W-1:0] c);
        logic [CELL_W-1:0] base;
        base = cell_at(cell_row(c), '0);
        return ROW_W'(c - base);
    endfunction

    function automatic logic [ROW_W-1:0] step_wrap(input logic [ROW_W-1:0] x);
        return (x == ROW_W'(SQUARE_SIDE - 1)) ? '0 : x + ROW_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/pce_ram.sv]
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module pce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/pce_front.sv]
// ============================================================================
// Playfair encryptor front end
// Accepts input words, drops bad letters, folds J into I, and queues commands.
// ============================================================================
`default_nettype none

`include "playfair_cipher_encrypt_macros.svh"

module pce_front
    import pce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [FUNC_W-1:0]   in_func,
    input  wire logic [LETTER_W-1:0] in_letter,
    output logic                     q_valid,
    output q_item_t                  q_item,
    input  wire logic                q_pop
);

    q_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                keep;
    logic                push;
    logic                pop;
    q_item_t             item_in;

    // Key and message letters past Z never reach the back end.
    assign keep = !(((in_func == FUNC_KEY) || (in_func == FUNC_MSG))
                    && (in_letter >= LETTER_W'(ALPHABET)));

    assign item_in.func = in_func;
    assign item_in.code = (in_letter == CODE_J) ? CODE_I : in_letter;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

    `PCE_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `PCE_ASSERT_IMPL(a_code_range,
                     q_valid && ((q_item.func == FUNC_KEY) || (q_item.func == FUNC_MSG)),
                     q_item.code < LETTER_W'(ALPHABET))
    `PCE_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

`default_nettype wire

[rtl/pce_back.sv]
// ============================================================================
// Playfair encryptor back end
// Builds the key square, tracks the open pair, enciphers pairs and flags unsealed messages.
// ============================================================================
`default_nettype none

`include "playfair_cipher_encrypt_macros.svh"

module pce_back
    import pce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire q_item_t             q_item,
    output logic                     q_pop,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic [LETTER_W-1:0]      out_first,
    output logic [LETTER_W-1:0]      out_second,
    output logic                     out_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEAL = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;
    localparam logic [1:0] ST_DATA = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [LETTER_W-1:0] sq_reg [CELL_COUNT];
    logic [CELL_W-1:0]   fill_count_reg;
    logic [ALPHABET-1:0] used_reg;
    logic                sealed_reg, sealed_next;
    logic                pending_valid_reg, pending_valid_next;
    logic [LETTER_W-1:0] pending_letter_reg, pending_letter_next;
    logic [LETTER_W-1:0] seal_cnt_reg, seal_cnt_next;
    logic [CELL_W-1:0]   pa_reg, pa_next;
    logic [CELL_W-1:0]   pb_reg, pb_next;
    logic                out_valid_reg;
    logic [LETTER_W-1:0] out_first_reg, out_second_reg;
    logic                out_status_reg;

    logic                slot_free;
    logic                place_req;
    logic                place_en;
    logic [LETTER_W-1:0] place_code;
    logic [LETTER_W-1:0] look_b;
    logic [CELL_W-1:0]   hit_a, hit_b;
    logic                err_load;
    logic                pair_load;
    logic                ram_re;
    logic [ROW_W-1:0]    ra, ca, rb, cb;
    logic [CELL_W-1:0]   fa, fb;
    logic [LETTER_W-1:0] rd_first, rd_second;

    assign slot_free = !out_valid_reg || out_ready;

    // The first letter of a pair is always the open one; a doubled letter
    // pairs with X just as the end command does.
    assign look_b = ((q_item.func == FUNC_MSG) && (pending_letter_reg != q_item.code))
                    ? q_item.code : CODE_X;

    // Parallel match over the square cells; after sealing every code is unique.
    always_comb
    begin
        hit_a = '0;
        hit_b = '0;
        for (int c = 0; c < CELL_COUNT; c++)
        begin
            if (sq_reg[c] == pending_letter_reg)
                hit_a = hit_a | CELL_W'(c);
            if (sq_reg[c] == look_b)
                hit_b = hit_b | CELL_W'(c);
        end
    end

    assign place_en = place_req && (fill_count_reg < CELL_W'(CELL_COUNT))
                      && !used_reg[place_code];

    always_comb
    begin
        state_next          = state_reg;
        sealed_next         = sealed_reg;
        pending_valid_next  = pending_valid_reg;
        pending_letter_next = pending_letter_reg;
        seal_cnt_next       = seal_cnt_reg;
        pa_next             = pa_reg;
        pb_next             = pb_reg;
        q_pop               = 1'b0;
        place_req           = 1'b0;
        place_code          = q_item.code;
        err_load            = 1'b0;
        pair_load           = 1'b0;
        ram_re              = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.func)
                        FUNC_KEY:
                        begin
                            q_pop     = 1'b1;
                            place_req = !sealed_reg;
                        end
                        FUNC_SEAL:
                        begin
                            q_pop = 1'b1;
                            if (!sealed_reg)
                            begin
                                seal_cnt_next = '0;
                                state_next    = ST_SEAL;
                            end
                        end
                        FUNC_MSG:
                        begin
                            priority if (!sealed_reg)
                            begin
                                if (slot_free)
                                begin
                                    q_pop    = 1'b1;
                                    err_load = 1'b1;
                                end
                            end
                            else if (!pending_valid_reg)
                            begin
                                q_pop               = 1'b1;
                                pending_valid_next  = 1'b1;
                                pending_letter_next = q_item.code;
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                pa_next    = hit_a;
                                pb_next    = hit_b;
                                state_next = ST_ADDR;
                                if (pending_letter_reg != q_item.code)
                                    pending_valid_next = 1'b0;
                            end
                        end
                        FUNC_END:
                        begin
                            q_pop = 1'b1;
                            if (sealed_reg && pending_valid_reg)
                            begin
                                pa_next            = hit_a;
                                pb_next            = hit_b;
                                state_next         = ST_ADDR;
                                pending_valid_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            ST_SEAL:
            begin
                // One alphabet letter per cycle, J skipped.
                place_req  = (seal_cnt_reg != CODE_J);
                place_code = seal_cnt_reg;
                if (seal_cnt_reg == LETTER_W'(ALPHABET - 1))
                begin
                    sealed_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                    seal_cnt_next = seal_cnt_reg + LETTER_W'(1);
            end
            ST_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    pair_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Cell rule: same row steps right, same column steps down, else swap columns.
    always_comb
    begin
        ra = cell_row(pa_reg);
        ca = cell_col(pa_reg);
        rb = cell_row(pb_reg);
        cb = cell_col(pb_reg);
        priority if (ra == rb)
        begin
            fa = cell_at(ra, step_wrap(ca));
            fb = cell_at(rb, step_wrap(cb));
        end
        else if (ca == cb)
        begin
            fa = cell_at(step_wrap(ra), ca);
            fb = cell_at(step_wrap(rb), cb);
        end
        else
        begin
            fa = cell_at(ra, cb);
            fb = cell_at(rb, ca);
        end
    end

    pce_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELL_COUNT)
    ) u_ram_first (
        .clk   (clk),
        .we    (place_en),
        .waddr (fill_count_reg),
        .wdata (place_code),
        .re    (ram_re),
        .raddr (fa),
        .rdata (rd_first)
    );

    pce_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELL_COUNT)
    ) u_ram_second (
        .clk   (clk),
        .we    (place_en),
        .waddr (fill_count_reg),
        .wdata (place_code),
        .re    (ram_re),
        .raddr (fb),
        .rdata (rd_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            for (int c = 0; c < CELL_COUNT; c++)
                sq_reg[c] <= '0;
            fill_count_reg     <= '0;
            used_reg           <= '0;
            sealed_reg         <= 1'b0;
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
            seal_cnt_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sealed_reg         <= sealed_next;
            pending_valid_reg  <= pending_valid_next;
            pending_letter_reg <= pending_letter_next;
            seal_cnt_reg       <= seal_cnt_next;
            if (place_en)
            begin
                sq_reg[fill_count_reg] <= place_code;
                fill_count_reg         <= fill_count_reg + CELL_W'(1);
                used_reg[place_code]   <= 1'b1;
            end
            if (err_load || pair_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        if (err_load)
        begin
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_status_reg <= 1'b1;
        end
        else if (pair_load)
        begin
            out_first_reg  <= rd_first;
            out_second_reg <= rd_second;
            out_status_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_status = out_status_reg;

    `PCE_ASSERT_IMPL(a_sealed_full, sealed_reg, fill_count_reg == CELL_W'(CELL_COUNT))
    `PCE_ASSERT_IMPL(a_used_count, 1'b1, $countones(used_reg) == int'(fill_count_reg))
    `PCE_ASSERT_IMPL(a_pending_sealed, pending_valid_reg, sealed_reg)
    `PCE_ASSERT_IMPL(a_data_after_addr, state_reg == ST_DATA,
                     $past(state_reg) == ST_ADDR || $past(state_reg) == ST_DATA)

endmodule

`default_nettype wire

[rtl/playfair_cipher_encrypt.sv]
// A message word that closes a pair passes the queue, the cell match, the RAM read and the output register.
// In the back end a key word is placed as it is popped; a pair goes through match, RAM read and output load.
// A seal command holds the back end while it walks the alphabet.
// A 2-word queue keeps input accepted, until it is full, while the back end works or the output stalls.
// Reset clears the square registers, letter set, open pair, queue and output valid; no clearing pass.
`default_nettype none

// ============================================================================
// Playfair encryptor top level
// Key schedule and pair encryption over letter codes 0 to 25.
// ============================================================================

module playfair_cipher_encrypt
    import pce_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [4:0] letter, [7:5] zero
    input  wire logic [FUNC_W-1:0]    s_axis_tuser,  // [1:0] func
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // [4:0] cipher_first, [9:5] cipher_second
    output logic [0:0]                m_axis_tuser   // [0] status
);

    logic                q_valid;
    q_item_t             q_item;
    logic                q_pop;
    logic [LETTER_W-1:0] cipher_first;
    logic [LETTER_W-1:0] cipher_second;
    logic                status;

    pce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_letter (s_axis_tdata[LETTER_W-1:0]),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    pce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_first  (cipher_first),
        .out_second (cipher_second),
        .out_status (status)
    );

    assign m_axis_tdata    = {{M_PAD_W{1'b0}}, cipher_second, cipher_first};
    assign m_axis_tuser[0] = status;

endmodule

`default_nettype wire
